/* rtl/core/epl_pkg.sv */
// Shared types, codes, constants and helpers for the exponential property law pipeline.
package epl_pkg;

	// Action codes carried on the input word.
	localparam logic [1:0] ACT_VALUE  = 2'd0;
	localparam logic [1:0] ACT_FIRST  = 2'd1;
	localparam logic [1:0] ACT_SECOND = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_BASE  = 2'd0;
	localparam logic [1:0] REG_RATE  = 2'd1;
	localparam logic [1:0] REG_REF   = 2'd2;
	localparam logic [1:0] REG_DEP   = 2'd3;

	localparam int unsigned NUM_VARIABLES = 16;
	localparam int unsigned HORNER_TERMS  = 10;

	localparam logic [31:0] BASE_RESET = 32'h0001_0000;

	localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
	localparam logic [31:0] LOG2E_Q31 = 32'd3098164009;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;

	// Exponent argument window in Q32.32: [-88, 64].
	localparam logic signed [64:0] ZMAX = 65'sd274877906944;
	localparam logic signed [64:0] ZMIN = -65'sd377957122048;

	// Per-item sideband that rides alongside the exponential datapath.
	typedef struct packed {
		logic               valid;
		logic               zero;
		logic               neg;
		logic signed [6:0]  exoff;
		logic signed [8:0]  nexp;
		logic [31:0]        mant;
	} ctl_t;

	// Right shift that brings a 64-bit product below 2^32.
	function automatic logic [5:0] norm_shift(input logic [63:0] v);
		logic [5:0] sh;
		sh = 6'd0;
		for (int b = 32; b < 64; b++) begin
			if (v[b]) begin
				sh = 6'(b - 31);
			end
		end
		return sh;
	endfunction

endpackage

/* rtl/core/epl_front.sv */
// Front stages: prefactor products and exponent range reduction down to the Horner argument.
module epl_front #(
	parameter int unsigned NUM_VARIABLES = epl_pkg::NUM_VARIABLES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [1:0]         action,
	input  logic signed [31:0] variable_value,
	input  logic [3:0]         first_variable,
	input  logic [3:0]         second_variable,
	input  logic signed [31:0] base_value,
	input  logic signed [31:0] rate_factor,
	input  logic signed [31:0] reference_point,
	input  logic [3:0]         dependent_variable,
	output epl_pkg::ctl_t      ctl_o,
	output logic [29:0]        y_o
);

	logic [31:0] kmag;
	logic [31:0] vmag;
	logic        dep_ok;
	logic        zero_in;
	logic        neg_in;

	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [32:0] d_s1;
	logic [63:0]        pre_s1;
	logic [31:0]        mag0_s1;
	logic [1:0]         act_s1;
	logic               zero_s1, neg_s1;

	logic signed [64:0] z_s2;
	logic [5:0]         sh1;
	logic [31:0]        n1_s2, mag0_s2;
	logic [5:0]         sh1_s2;
	logic [1:0]         act_s2;
	logic               zero_s2, neg_s2;

	logic signed [64:0] zc;
	logic signed [31:0] t_s3;
	logic [63:0]        pre2_s3;
	logic [31:0]        n1_s3, mag0_s3;
	logic [5:0]         sh1_s3;
	logic [1:0]         act_s3;
	logic               zero_s3, neg_s3;

	logic [63:0]        p_s4;
	logic [5:0]         sh2;
	logic [31:0]        n1_s4, n2_s4, mag0_s4;
	logic [5:0]         sh1_s4, sh2_s4;
	logic [1:0]         act_s4;
	logic               zero_s4, neg_s4;

	logic [59:0]        yprod;
	epl_pkg::ctl_t      ctl_d;
	epl_pkg::ctl_t      ctl_s5;
	logic [29:0]        y_s5;

	assign kmag   = rate_factor[31] ? (~rate_factor + 32'd1) : rate_factor;
	assign vmag   = base_value[31] ? (~base_value + 32'd1) : base_value;
	assign dep_ok = 32'(dependent_variable) < NUM_VARIABLES;

	// Flag every item whose answer is a plain zero.
	always_comb begin
		zero_in = (base_value == 32'sd0);
		case (action)
			epl_pkg::ACT_VALUE: begin
			end
			epl_pkg::ACT_FIRST: begin
				zero_in = zero_in | !dep_ok | (first_variable != dependent_variable)
					| (rate_factor == 32'sd0);
			end
			epl_pkg::ACT_SECOND: begin
				zero_in = zero_in | !dep_ok | (first_variable != dependent_variable)
					| (second_variable != dependent_variable) | (rate_factor == 32'sd0);
			end
			default: begin
				zero_in = 1'b1;
			end
		endcase
	end

	assign neg_in = (action == epl_pkg::ACT_FIRST) ? !(base_value[31] ^ rate_factor[31])
		: base_value[31];

	assign sh1 = epl_pkg::norm_shift(pre_s1);
	assign sh2 = epl_pkg::norm_shift(pre2_s3);

	always_comb begin
		zc = z_s2;
		if (z_s2 > epl_pkg::ZMAX) begin
			zc = epl_pkg::ZMAX;
		end else if (z_s2 < epl_pkg::ZMIN) begin
			zc = epl_pkg::ZMIN;
		end
	end

	assign yprod = 60'(p_s4[54:25]) * 60'(epl_pkg::LN2_Q30);

	// Pick the prefactor for the action and fold its scaling into one offset.
	always_comb begin
		ctl_d       = '0;
		ctl_d.valid = v_s4;
		ctl_d.zero  = zero_s4;
		ctl_d.neg   = neg_s4;
		ctl_d.nexp  = p_s4[63:55];
		case (act_s4)
			epl_pkg::ACT_FIRST: begin
				ctl_d.mant  = n1_s4;
				ctl_d.exoff = {1'b0, sh1_s4} - 7'd16;
			end
			epl_pkg::ACT_SECOND: begin
				ctl_d.mant  = n2_s4;
				ctl_d.exoff = {1'b0, sh1_s4} + {1'b0, sh2_s4} - 7'd32;
			end
			default: begin
				ctl_d.mant  = mag0_s4;
				ctl_d.exoff = 7'sd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			ctl_s5 <= '0;
		end else if (en) begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			ctl_s5 <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= {reference_point[31], reference_point}
				- {variable_value[31], variable_value};
			pre_s1  <= 64'(vmag) * 64'(kmag);
			mag0_s1 <= vmag;
			act_s1  <= action;
			zero_s1 <= zero_in;
			neg_s1  <= neg_in;

			z_s2    <= 65'(rate_factor) * 65'(d_s1);
			n1_s2   <= 32'(pre_s1 >> sh1);
			sh1_s2  <= sh1;
			mag0_s2 <= mag0_s1;
			act_s2  <= act_s1;
			zero_s2 <= zero_s1;
			neg_s2  <= neg_s1;

			t_s3    <= zc[39:8];
			pre2_s3 <= 64'(n1_s2) * 64'(kmag);
			n1_s3   <= n1_s2;
			sh1_s3  <= sh1_s2;
			mag0_s3 <= mag0_s2;
			act_s3  <= act_s2;
			zero_s3 <= zero_s2;
			neg_s3  <= neg_s2;

			p_s4    <= 64'(65'(t_s3) * 65'($signed({1'b0, epl_pkg::LOG2E_Q31})));
			n2_s4   <= 32'(pre2_s3 >> sh2);
			sh2_s4  <= sh2;
			n1_s4   <= n1_s3;
			sh1_s4  <= sh1_s3;
			mag0_s4 <= mag0_s3;
			act_s4  <= act_s3;
			zero_s4 <= zero_s3;
			neg_s4  <= neg_s3;

			y_s5    <= yprod[59:30];
		end
	end

	assign ctl_o = ctl_s5;
	assign y_o   = y_s5;

endmodule

/* rtl/core/epl_horner_step.sv */
// One Horner term of the exponential series: multiply, divide by a constant, add one.
module epl_horner_step #(
	parameter int DIV = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  epl_pkg::ctl_t ctl_i,
	input  logic [31:0]   acc_i,
	input  logic [29:0]   y_i,
	output epl_pkg::ctl_t ctl_o,
	output logic [31:0]   acc_o,
	output logic [29:0]   y_o
);

	localparam logic [32:0] RECIP = 33'((65'd1 << 32) / DIV);
	localparam logic [31:0] DIV_V = 32'(DIV);

	epl_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic [29:0]   y_s1, y_s2, y_s3;
	logic [61:0]   hprod;
	logic [31:0]   h_s1, h_s2;
	logic [64:0]   qprod;
	logic [31:0]   q0_s2;
	logic [31:0]   rem;
	logic [31:0]   q;
	logic [31:0]   acc_s3;

	assign hprod = 62'(acc_i) * 62'(y_i);
	assign qprod = 65'(h_s1) * 65'(RECIP);

	// Reciprocal estimate is low by at most one: fix it with the remainder.
	assign rem = h_s2 - 32'(q0_s2 * DIV_V);
	assign q   = (rem >= DIV_V) ? q0_s2 + 32'd1 : q0_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1   <= hprod[61:30];
			y_s1   <= y_i;
			q0_s2  <= qprod[63:32];
			h_s2   <= h_s1;
			y_s2   <= y_s1;
			acc_s3 <= epl_pkg::ONE_Q30 + q;
			y_s3   <= y_s2;
		end
	end

	assign ctl_o = ctl_s3;
	assign acc_o = acc_s3;
	assign y_o   = y_s3;

endmodule

/* rtl/core/epl_back.sv */
// Back stages: final product, Q16.16 alignment with saturation, output register and skid.
module epl_back (
	input  logic               clk,
	input  logic               arst_n,
	input  epl_pkg::ctl_t      ctl_i,
	input  logic [31:0]        acc_i,
	input  logic               out_stall,
	output logic               out_valid,
	output logic signed [31:0] result,
	output logic               saturated,
	output logic               adv
);

	epl_pkg::ctl_t     ctl_s1, ctl_s2, ctl_s3;
	logic [63:0]       prod_s1;
	logic [5:0]        sh3;
	logic [31:0]       mant_s2;
	logic signed [9:0] s_s2;
	logic [31:0]       lim;
	logic [63:0]       wide;
	logic [9:0]        rsh;
	logic [31:0]       mag_d;
	logic              sat_d;
	logic [31:0]       mag_s3;
	logic              sat_s3;

	logic [31:0] fin_val;
	logic        fin_sat;
	logic        take;
	logic        incoming;
	logic        out_v_q, skid_v_q;
	logic [31:0] result_q, skid_res_q;
	logic        sat_q, skid_sat_q;

	assign sh3 = epl_pkg::norm_shift(prod_s1);

	assign lim  = ctl_s2.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign wide = 64'(mant_s2) << s_s2[4:0];
	assign rsh  = 10'd0 - s_s2;

	// Align the mantissa into Q16.16, clip on overflow, drop to zero on underflow.
	always_comb begin
		mag_d = 32'd0;
		sat_d = 1'b0;
		if (!s_s2[9]) begin
			if (s_s2 > 10'sd31 || wide > {32'd0, lim}) begin
				mag_d = lim;
				sat_d = 1'b1;
			end else begin
				mag_d = wide[31:0];
			end
		end else if (rsh < 10'd32) begin
			mag_d = mant_s2 >> rsh[4:0];
		end
	end

	assign fin_val = ctl_s3.zero ? 32'd0 : (ctl_s3.neg ? 32'd0 - mag_s3 : mag_s3);
	assign fin_sat = !ctl_s3.zero & sat_s3;

	// Keep the pipe moving until the skid word is occupied.
	assign adv      = !skid_v_q;
	assign take     = out_v_q & !out_stall;
	assign incoming = ctl_s3.valid & adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			ctl_s2   <= '0;
			ctl_s3   <= '0;
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (adv) begin
				ctl_s1 <= ctl_i;
				ctl_s2 <= ctl_s1;
				ctl_s3 <= ctl_s2;
			end
			if (skid_v_q) begin
				skid_v_q <= !take;
			end else if (incoming) begin
				out_v_q  <= 1'b1;
				skid_v_q <= out_v_q & !take;
			end else if (take) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= 64'(ctl_i.mant) * 64'(acc_i);
			mant_s2 <= 32'(prod_s1 >> sh3);
			s_s2    <= {{3{ctl_s1.exoff[6]}}, ctl_s1.exoff} + {4'd0, sh3}
				+ {ctl_s1.nexp[8], ctl_s1.nexp} - 10'sd30;
			mag_s3  <= mag_d;
			sat_s3  <= sat_d;
		end
		if (skid_v_q) begin
			if (take) begin
				result_q <= skid_res_q;
				sat_q    <= skid_sat_q;
			end
		end else if (incoming) begin
			if (!out_v_q || take) begin
				result_q <= fin_val;
				sat_q    <= fin_sat;
			end else begin
				skid_res_q <= fin_val;
				skid_sat_q <= fin_sat;
			end
		end
	end

	assign out_valid = out_v_q;
	assign result    = result_q;
	assign saturated = sat_q;

endmodule

/* rtl/core/exponential_property_law.sv */
// Top level of the exponential property law: f = v0*exp(-k*(x - xref)) and its derivatives.
// An accepted input word runs through the front stages, the Horner steps and the back stages to out_valid.
// Throughput: one word per cycle while in_stall is low; each stage holds at most one multiplier, and the ten-term
// Horner series of the exponential takes 30 of the 39 stages.
// Reset: arst_n clears every valid bit and the skid word and loads the register defaults.
module exponential_property_law #(
	parameter int unsigned NUM_VARIABLES = epl_pkg::NUM_VARIABLES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic signed [31:0] variable_value,
	input  logic [3:0]         first_variable,
	input  logic [3:0]         second_variable,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result,
	output logic               saturated
);

	localparam int unsigned TERMS = epl_pkg::HORNER_TERMS;

	logic signed [31:0] base_value_q;
	logic signed [31:0] rate_factor_q;
	logic signed [31:0] reference_point_q;
	logic [3:0]         dependent_variable_q;

	logic          adv;
	epl_pkg::ctl_t ctl_c [TERMS+1];
	logic [31:0]   acc_c [TERMS+1];
	logic [29:0]   y_c   [TERMS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_value_q         <= epl_pkg::BASE_RESET;
			rate_factor_q        <= 32'sd0;
			reference_point_q    <= 32'sd0;
			dependent_variable_q <= 4'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				epl_pkg::REG_BASE: base_value_q         <= cfg_data;
				epl_pkg::REG_RATE: rate_factor_q        <= cfg_data;
				epl_pkg::REG_REF:  reference_point_q    <= cfg_data;
				epl_pkg::REG_DEP:  dependent_variable_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall = !adv;

	epl_front #(
		.NUM_VARIABLES (NUM_VARIABLES)
	) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.en                 (adv),
		.in_valid           (in_valid),
		.action             (action),
		.variable_value     (variable_value),
		.first_variable     (first_variable),
		.second_variable    (second_variable),
		.base_value         (base_value_q),
		.rate_factor        (rate_factor_q),
		.reference_point    (reference_point_q),
		.dependent_variable (dependent_variable_q),
		.ctl_o              (ctl_c[0]),
		.y_o                (y_c[0])
	);

	assign acc_c[0] = epl_pkg::ONE_Q30;

	// Horner from the highest term down: divide by 10, 9, ... 1.
	for (genvar g = 0; g < TERMS; g++) begin : g_horner
		if (g == TERMS - 1) begin : g_last
			epl_horner_step #(.DIV(int'(TERMS) - g)) u_step (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (adv),
				.ctl_i  (ctl_c[g]),
				.acc_i  (acc_c[g]),
				.y_i    (y_c[g]),
				.ctl_o  (ctl_c[g+1]),
				.acc_o  (acc_c[g+1]),
				.y_o    ()
			);
		end else begin : g_mid
			epl_horner_step #(.DIV(int'(TERMS) - g)) u_step (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (adv),
				.ctl_i  (ctl_c[g]),
				.acc_i  (acc_c[g]),
				.y_i    (y_c[g]),
				.ctl_o  (ctl_c[g+1]),
				.acc_o  (acc_c[g+1]),
				.y_o    (y_c[g+1])
			);
		end
	end

	epl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_i     (ctl_c[TERMS]),
		.acc_i     (acc_c[TERMS]),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.result    (result),
		.saturated (saturated),
		.adv       (adv)
	);

endmodule

/* rtl/core/epl_checker.sv */
// Port-level checks for the exponential property law, bound to the top level.
module epl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] result,
	input logic        saturated
);

	// Hold a stalled output word.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result) && $stable(saturated))
		else $error("output word changed while stalled");

	// A clipped word sits at one of the two extremes.
	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> result == 32'h7FFF_FFFF || result == 32'h8000_0000)
		else $error("saturated word not at an extreme value");

	// Back-pressure only starts after the output was held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stalled without a held output word");

	// Input stall means the skid word is occupied; check that the output word is occupied too.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with an empty output");

endmodule

bind exponential_property_law epl_checker u_epl_checker (.*);
